// ===== rtl/psq_pkg.sv =====
// Shared types, constants and the control program of the pitch scale quantizer.
package psq_pkg;

    localparam int PitchW    = 24;                 // input pitch width
    localparam int OutW      = 17;                 // snapped pitch width
    localparam int RoundW    = 17;                 // rounded integer pitch
    localparam int MagW      = 16;                 // magnitude of rounded pitch
    localparam int DivW      = 8;                  // divisions register
    localparam int CountW    = 5;                  // step_count register
    localparam int StepsW    = 48;                 // steps_low / steps_high
    localparam int StepW     = 6;                  // one step size
    localparam int MaxSteps  = 16;
    localparam int IdxW      = $clog2(MaxSteps + 1);
    localparam int BoundW    = 10;                 // cumulative boundary
    localparam int CfgIdxW   = 2;
    localparam int CfgDataW  = 48;
    localparam int SDataW    = 24;
    localparam int MDataW    = 24;
    localparam int PcW       = 3;
    localparam int DivCntW   = $clog2(MagW);

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] REG_DIVISIONS  = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_STEP_COUNT = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_STEPS_LOW  = 2'd2;
    localparam logic [CfgIdxW-1:0] REG_STEPS_HIGH = 2'd3;

    localparam logic [DivW-1:0]   DivisionsRst = 8'd12;
    localparam logic [CountW-1:0] StepCountRst = 5'd7;
    localparam logic [StepsW-1:0] StepsLowRst  = 48'd70901043330;
    localparam logic [StepsW-1:0] StepsHighRst = 48'd0;

    // program counter values
    localparam logic [PcW-1:0] PC_WAIT = 3'd0;
    localparam logic [PcW-1:0] PC_DIV  = 3'd1;
    localparam logic [PcW-1:0] PC_FIX  = 3'd2;
    localparam logic [PcW-1:0] PC_WALK = 3'd3;
    localparam logic [PcW-1:0] PC_OUT  = 3'd4;
    localparam logic [PcW-1:0] PC_BACK = 3'd5;

    typedef enum logic [2:0] {
        C_NEVER,
        C_NO_IN,
        C_DIV_MORE,
        C_WALK_MORE,
        C_OUT_BUSY,
        C_ALWAYS
    } cond_t;

    typedef struct packed {
        logic ld_in;
        logic div_step;
        logic fix_rem;
        logic walk_step;
        logic ld_out;
    } ops_t;

    typedef struct packed {
        ops_t             ops;
        cond_t            cond;
        logic [PcW-1:0]   target;
    } ctrl_word_t;

    // Microcode ROM: jump to target when cond holds, else fall through.
    function automatic ctrl_word_t ucode_rom(input logic [PcW-1:0] pc);
        ctrl_word_t cw;
        cw = '{ops: '0, cond: C_ALWAYS, target: PC_WAIT};
        case (pc)
            PC_WAIT: begin
                cw.ops.ld_in = 1'b1;
                cw.cond      = C_NO_IN;
                cw.target    = PC_WAIT;
            end
            PC_DIV: begin
                cw.ops.div_step = 1'b1;
                cw.cond         = C_DIV_MORE;
                cw.target       = PC_DIV;
            end
            PC_FIX: begin
                cw.ops.fix_rem = 1'b1;
                cw.cond        = C_NEVER;
            end
            PC_WALK: begin
                cw.ops.walk_step = 1'b1;
                cw.cond          = C_WALK_MORE;
                cw.target        = PC_WALK;
            end
            PC_OUT: begin
                cw.ops.ld_out = 1'b1;
                cw.cond       = C_OUT_BUSY;
                cw.target     = PC_OUT;
            end
            default: begin
                cw.cond   = C_ALWAYS;
                cw.target = PC_WAIT;
            end
        endcase
        return cw;
    endfunction

    // Pick step idx out of the two packed step registers.
    function automatic logic [StepW-1:0] step_size(input logic [StepsW-1:0] lo_word,
                                                   input logic [StepsW-1:0] hi_word,
                                                   input logic [3:0] idx);
        logic [StepsW-1:0] word;
        word = idx[3] ? hi_word : lo_word;
        return word[StepW*idx[2:0] +: StepW];
    endfunction

endpackage

// ===== rtl/pitch_scale_quantizer_unit.sv =====
// Pitch scale quantizer: microcoded sequencer that snaps a pitch to a scale degree.
// Each item runs 16 divide steps, one fixup, 1 to 17 scale walk steps and one output load;
// a new beat is accepted only once the sequencer is back at its wait step. The pace is set
// by the one-bit-per-cycle remainder loop and the serial walk over the step sizes.
// A finished result waits in the output register while the next beat is accepted.
// Reset (aresetn low, synchronous) returns the sequencer to its wait step, drops m_tvalid
// and loads the configuration registers with their default C major scale.
module pitch_scale_quantizer_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration write port
    input  logic                          cfg_wr_en,
    input  logic [psq_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [psq_pkg::CfgDataW-1:0]  cfg_wr_data,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [psq_pkg::SDataW-1:0]    s_tdata,   // [23:0] pitch_in
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [psq_pkg::MDataW-1:0]    m_tdata    // [16:0] pitch_out, [23:17] zero
);
    import psq_pkg::*;

    // ---------------- configuration registers ----------------
    logic [DivW-1:0]   divisions_reg;
    logic [CountW-1:0] step_count_reg;
    logic [StepsW-1:0] steps_low_reg;
    logic [StepsW-1:0] steps_high_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            divisions_reg  <= DivisionsRst;
            step_count_reg <= StepCountRst;
            steps_low_reg  <= StepsLowRst;
            steps_high_reg <= StepsHighRst;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_DIVISIONS:  divisions_reg  <= cfg_wr_data[DivW-1:0];
                REG_STEP_COUNT: step_count_reg <= cfg_wr_data[CountW-1:0];
                REG_STEPS_LOW:  steps_low_reg  <= cfg_wr_data[StepsW-1:0];
                REG_STEPS_HIGH: steps_high_reg <= cfg_wr_data[StepsW-1:0];
                default: ;
            endcase
        end
    end

    // Zero divisions acts as one; oversized step counts clamp to the table size.
    logic [DivW-1:0]   dvs;
    logic [IdxW-1:0]   n_steps;
    assign dvs     = (divisions_reg == '0) ? DivW'(1) : divisions_reg;
    assign n_steps = (step_count_reg > CountW'(MaxSteps)) ? IdxW'(MaxSteps)
                                                          : IdxW'(step_count_reg);

    // ---------------- sequencer ----------------
    logic [PcW-1:0] pc_reg, pc_next;
    ctrl_word_t     cw;
    logic           take_jump;

    // ---------------- datapath registers ----------------
    logic signed [RoundW-1:0] round_reg;     // rounded integer pitch
    logic                     neg_reg;       // rounded pitch below zero
    logic [MagW-1:0]          dvd_reg;       // dividend bits, MSB first
    logic [DivW-1:0]          rem_reg;       // partial remainder of |R| / d
    logic [DivCntW-1:0]       cnt_reg;       // divide steps left after the current one
    logic [BoundW-1:0]        m_reg;         // remainder, later snapped degree
    logic signed [RoundW:0]   base_reg;      // R minus the wrapped remainder
    logic [BoundW-1:0]        lo_reg;        // lower boundary of current step
    logic [IdxW-1:0]          idx_reg;       // step index of the walk
    logic [OutW-1:0]          out_reg;
    logic                     m_valid_reg;

    // input rounding: floor((p + 128) / 256)
    logic signed [PitchW:0]   p_biased;
    logic signed [RoundW-1:0] round_in;
    logic [RoundW-1:0]        round_abs;
    assign p_biased  = $signed({s_tdata[PitchW-1], s_tdata[PitchW-1:0]})
                     + (PitchW+1)'(128);
    assign round_in  = RoundW'(p_biased >>> 8);
    assign round_abs = round_in[RoundW-1] ? RoundW'(-round_in) : RoundW'(round_in);

    // restoring divide step
    logic [DivW:0] rem_shift;
    logic          rem_ge;
    assign rem_shift = {rem_reg, dvd_reg[MagW-1]};
    assign rem_ge    = rem_shift >= {1'b0, dvs};

    // floor-mod fixup for negative pitches
    logic [DivW-1:0] m_wrapped;
    assign m_wrapped = (neg_reg && rem_reg != '0) ? DivW'(dvs - rem_reg) : rem_reg;

    // scale walk
    logic [StepW-1:0]  dia;
    logic [BoundW-1:0] hi;
    logic              in_range;
    logic              below_hi;
    logic              snap_low;
    logic              walk_more;
    assign dia       = step_size(steps_low_reg, steps_high_reg, idx_reg[3:0]);
    assign hi        = lo_reg + BoundW'(dia);
    assign in_range  = idx_reg < n_steps;
    assign below_hi  = m_reg < hi;
    assign snap_low  = {m_reg, 1'b0} < ({lo_reg, 1'b0} + (BoundW+1)'(dia));
    assign walk_more = in_range && !below_hi;

    logic out_free;
    assign out_free = !m_valid_reg || m_tready;

    assign cw       = ucode_rom(pc_reg);
    assign s_tready = cw.ops.ld_in;

    always_comb begin
        case (cw.cond)
            C_NEVER:     take_jump = 1'b0;
            C_NO_IN:     take_jump = !s_tvalid;
            C_DIV_MORE:  take_jump = cnt_reg != '0;
            C_WALK_MORE: take_jump = walk_more;
            C_OUT_BUSY:  take_jump = !out_free;
            C_ALWAYS:    take_jump = 1'b1;
            default:     take_jump = 1'b0;
        endcase
        pc_next = take_jump ? cw.target : PcW'(pc_reg + PcW'(1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg      <= PC_WAIT;
            m_valid_reg <= 1'b0;
        end else begin
            pc_reg <= pc_next;
            if (cw.ops.ld_out && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (cw.ops.ld_in && s_tvalid) begin
            round_reg <= round_in;
            neg_reg   <= round_in[RoundW-1];
            dvd_reg   <= round_abs[MagW-1:0];
            rem_reg   <= '0;
            cnt_reg   <= DivCntW'(MagW - 1);
        end
        if (cw.ops.div_step) begin
            // shift one dividend bit in, subtract when it fits
            rem_reg <= rem_ge ? DivW'(rem_shift - {1'b0, dvs}) : rem_shift[DivW-1:0];
            dvd_reg <= {dvd_reg[MagW-2:0], 1'b0};
            cnt_reg <= cnt_reg - DivCntW'(1);
        end
        if (cw.ops.fix_rem) begin
            m_reg    <= BoundW'(m_wrapped);
            base_reg <= (RoundW+1)'(round_reg) - $signed({{(RoundW+1-DivW){1'b0}}, m_wrapped});
            lo_reg   <= '0;
            idx_reg  <= '0;
        end
        if (cw.ops.walk_step && in_range) begin
            if (below_hi) begin
                // snap to the nearer boundary, halves go up
                m_reg <= snap_low ? lo_reg : hi;
            end else begin
                lo_reg  <= hi;
                idx_reg <= idx_reg + IdxW'(1);
            end
        end
        if (cw.ops.ld_out && out_free) begin
            out_reg <= OutW'(base_reg + $signed({{(RoundW+1-BoundW){1'b0}}, m_reg}));
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(MDataW-OutW){1'b0}}, out_reg};

    // ---------------- assertions ----------------
    a_accept_starts_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> pc_reg == PC_DIV)
        else $error("accepted beat did not start the divide loop");

    a_rem_below_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (pc_reg == PC_FIX) |-> rem_reg < dvs)
        else $error("remainder not below divisions after divide loop");

    a_valid_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(pc_reg) == PC_OUT)
        else $error("result raised outside the output step");

    a_walk_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (pc_reg == PC_WALK) |-> idx_reg <= n_steps)
        else $error("scale walk ran past the step count");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (pc_reg != PC_WAIT) |-> !s_tready)
        else $error("input ready while an item is in flight");

endmodule
